// ===== src/pdcc_pkg.sv =====
package pdcc_pkg;

	localparam int STACK_ENTRIES = 32;
	localparam int MAX_NODES     = 65536;

	localparam int FILL_W  = $clog2(STACK_ENTRIES + 1);
	localparam int NEXT_W  = $clog2(MAX_NODES + 1);
	localparam int DEPTH_W = 5;
	localparam int INDEX_W = 16;
	localparam int COUNT_W = 16;
	localparam int LEAF_W  = 17;

	// one open ancestor
	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic [INDEX_W-1:0] index;
		logic [COUNT_W-1:0] kids;
	} entry_t;

	// shift command for the whole row of cells
	typedef struct packed {
		logic push;
		logic pop;
		logic bump;
	} stack_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WORK,
		ST_FLUSH
	} state_t;

endpackage

// ===== src/pdcc_cell.sv =====
module pdcc_cell
	import pdcc_pkg::*;
(
	input  logic      clk,
	input  stack_op_t op,
	input  logic      bump,
	input  entry_t    shift_in,
	input  entry_t    pop_in,
	output entry_t    q,
	output entry_t    fwd
);

	entry_t q_q;

	// bumped view, saturating child count
	always_comb begin
		fwd = q_q;
		if (bump && (q_q.kids != {COUNT_W{1'b1}})) begin
			fwd.kids = q_q.kids + COUNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (op.push) begin
			q_q <= shift_in;
		end else if (op.pop) begin
			q_q <= pop_in;
		end else if (bump) begin
			q_q <= fwd;
		end
	end

	assign q = q_q;

endmodule

// ===== src/pdcc_stack.sv =====
module pdcc_stack
	import pdcc_pkg::*;
(
	input  logic      clk,
	input  stack_op_t op,
	input  entry_t    new_entry,
	output entry_t    top,
	output entry_t    second
);

	entry_t q_w   [STACK_ENTRIES];
	entry_t fwd_w [STACK_ENTRIES];

	// cell 0 is the top; push moves everything one cell deeper
	for (genvar i = 0; i < STACK_ENTRIES; i++) begin : g_cell
		entry_t shift_in_w;
		entry_t pop_in_w;
		logic   bump_w;

		if (i == 0) begin : g_head
			assign shift_in_w = new_entry;
			assign bump_w     = op.bump;
		end else begin : g_body
			assign shift_in_w = fwd_w[i-1];
			assign bump_w     = 1'b0;
		end

		if (i == STACK_ENTRIES - 1) begin : g_tail
			assign pop_in_w = '0;
		end else begin : g_link
			assign pop_in_w = q_w[i+1];
		end

		pdcc_cell u_cell (
			.clk      (clk),
			.op       (op),
			.bump     (bump_w),
			.shift_in (shift_in_w),
			.pop_in   (pop_in_w),
			.q        (q_w[i]),
			.fwd      (fwd_w[i])
		);
	end

	assign top    = q_w[0];
	assign second = q_w[1];

endmodule

// ===== src/preorder_depth_child_counter.sv =====
// A node is taken in ST_IDLE; ST_WORK closes each ancestor at its depth or deeper, then
//   opens the node. A result sits in the output register the cycle after its pop.
// A new node waits until the last is opened or closed; a final node then closes every
//   entry still open. The stack row closes one entry per cycle while output can accept.
// Reset: arst_n clears sequencer, counters and result_valid; stack cells and data registers hold no reset.
module preorder_depth_child_counter
	import pdcc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                node_valid,
	output logic                node_ready,
	input  logic [DEPTH_W-1:0]  node_depth,
	input  logic                final_node,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [INDEX_W-1:0]  node_index,
	output logic [COUNT_W-1:0]  child_count,
	output logic                run_last,
	output logic                tree_done,
	output logic [LEAF_W-1:0]   leaf_total,
	output logic [COUNT_W-1:0]  largest_child_count,
	output logic                tree_valid
);

	// sequencer and tree state
	state_t             state_q, state_nx;
	logic [FILL_W-1:0]  fill_q;
	logic [NEXT_W-1:0]  next_q;
	logic [DEPTH_W-1:0] prev_depth_q;
	logic [LEAF_W-1:0]  tally_q;
	logic [COUNT_W-1:0] largest_q;
	logic               valid_q;

	// node being worked on
	logic [DEPTH_W-1:0] cur_depth_q;
	logic               cur_final_q;
	logic [INDEX_W-1:0] cur_index_q;

	// output beat register
	logic               res_valid_q;
	logic [INDEX_W-1:0] res_index_q;
	logic [COUNT_W-1:0] res_kids_q;
	logic               res_last_q;
	logic               res_done_q;
	logic [LEAF_W-1:0]  res_leaf_q;
	logic [COUNT_W-1:0] res_largest_q;
	logic               res_tree_valid_q;

	// stack row
	stack_op_t op;
	entry_t    new_entry;
	entry_t    top;
	entry_t    second;

	pdcc_stack u_stack (
		.clk       (clk),
		.op        (op),
		.new_entry (new_entry),
		.top       (top),
		.second    (second)
	);

	assign new_entry = '{depth: cur_depth_q, index: cur_index_q, kids: '0};

	logic accept;
	logic can_emit;
	logic pop_hit;
	logic more_pops;
	logic stack_full;

	assign node_ready = (state_q == ST_IDLE);
	assign accept     = node_valid && node_ready;
	// output slot is free now or drains this cycle
	assign can_emit   = !res_valid_q || result_ready;
	assign stack_full = (fill_q == FILL_W'(STACK_ENTRIES));
	// top must close when its depth is not below the new node's depth
	assign pop_hit    = (fill_q != '0) && (top.depth >= cur_depth_q);
	// lookahead: will the entry under the top close as well?
	assign more_pops  = (fill_q > FILL_W'(1)) && (second.depth >= cur_depth_q);

	// emit controls
	logic               emit;
	logic [INDEX_W-1:0] e_index;
	logic [COUNT_W-1:0] e_kids;
	logic               e_last;
	logic               e_done;
	logic               drop_full;

	always_comb begin
		state_nx  = state_q;
		op        = '0;
		emit      = 1'b0;
		e_index   = top.index;
		e_kids    = top.kids;
		e_last    = 1'b0;
		e_done    = 1'b0;
		drop_full = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nx = ST_WORK;
				end
			end
			ST_WORK: begin
				if (pop_hit) begin
					if (can_emit) begin
						emit   = 1'b1;
						op.pop = 1'b1;
						e_last = !cur_final_q && !more_pops;
					end
				end else if (!stack_full) begin
					// open the node; parent on top gains a child
					op.push  = 1'b1;
					op.bump  = (fill_q != '0);
					state_nx = cur_final_q ? ST_FLUSH : ST_IDLE;
				end else if (can_emit) begin
					// no room: parent still counts it, node closes at once
					op.bump   = 1'b1;
					emit      = 1'b1;
					drop_full = 1'b1;
					e_index   = cur_index_q;
					e_kids    = '0;
					e_last    = !cur_final_q;
					state_nx  = cur_final_q ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (fill_q == '0) begin
					state_nx = ST_IDLE;
				end else if (can_emit) begin
					emit   = 1'b1;
					op.pop = 1'b1;
					e_last = (fill_q == FILL_W'(1));
					e_done = e_last;
					if (e_last) begin
						state_nx = ST_IDLE;
					end
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// statistics including the node closing now
	logic [LEAF_W-1:0]  tally_nx;
	logic [COUNT_W-1:0] largest_nx;
	logic               valid_nx;

	always_comb begin
		tally_nx   = tally_q;
		largest_nx = largest_q;
		valid_nx   = valid_q;
		if (emit) begin
			if ((e_kids == '0) && (tally_q != {LEAF_W{1'b1}})) begin
				tally_nx = tally_q + LEAF_W'(1);
			end
			if (e_kids > largest_q) begin
				largest_nx = e_kids;
			end
			if ((e_kids == COUNT_W'(1)) || drop_full) begin
				valid_nx = 1'b0;
			end
		end
	end

	logic [DEPTH_W:0] depth_limit;
	logic             overflow;

	assign depth_limit = {1'b0, prev_depth_q} + (DEPTH_W+1)'(1);
	assign overflow    = (next_q == NEXT_W'(MAX_NODES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			next_q       <= '0;
			prev_depth_q <= '0;
			tally_q      <= '0;
			largest_q    <= '0;
			valid_q      <= 1'b1;
		end else if (e_done) begin
			// tree finished: start over
			fill_q       <= '0;
			next_q       <= '0;
			prev_depth_q <= '0;
			tally_q      <= '0;
			largest_q    <= '0;
			valid_q      <= 1'b1;
		end else if (accept) begin
			prev_depth_q <= node_depth;
			if (!overflow) begin
				next_q <= next_q + NEXT_W'(1);
			end
			if (overflow || ({1'b0, node_depth} > depth_limit)) begin
				valid_q <= 1'b0;
			end
		end else begin
			tally_q   <= tally_nx;
			largest_q <= largest_nx;
			valid_q   <= valid_nx;
			if (op.push) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (op.pop) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_depth_q <= node_depth;
			cur_final_q <= final_node;
			cur_index_q <= INDEX_W'(next_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_index_q      <= e_index;
			res_kids_q       <= e_kids;
			res_last_q       <= e_last;
			res_done_q       <= e_done;
			res_leaf_q       <= e_done ? tally_nx : '0;
			res_largest_q    <= e_done ? largest_nx : '0;
			res_tree_valid_q <= e_done && valid_nx;
		end
	end

	assign result_valid        = res_valid_q;
	assign node_index          = res_index_q;
	assign child_count         = res_kids_q;
	assign run_last            = res_last_q;
	assign tree_done           = res_done_q;
	assign leaf_total          = res_leaf_q;
	assign largest_child_count = res_largest_q;
	assign tree_valid          = res_tree_valid_q;

endmodule

// ===== src/pdcc_checker.sv =====
module pdcc_checker
	import pdcc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic               result_ready,
	input logic [INDEX_W-1:0] node_index,
	input logic               run_last,
	input logic               tree_done,
	input logic [LEAF_W-1:0]  leaf_total,
	input logic [COUNT_W-1:0] largest_child_count,
	input logic               tree_valid
);

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(node_index))
		else $error("result beat changed while stalled");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && tree_done |-> run_last)
		else $error("tree end not marked as last beat");

	a_summary_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !tree_done |->
			(leaf_total == '0) && (largest_child_count == '0) && !tree_valid)
		else $error("tree summary on a non-final beat");

	// every tree has at least one leaf
	a_has_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && tree_done |-> (leaf_total != '0))
		else $error("finished tree reports no leaf");

endmodule

bind preorder_depth_child_counter pdcc_checker u_pdcc_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.result_valid        (result_valid),
	.result_ready        (result_ready),
	.node_index          (node_index),
	.run_last            (run_last),
	.tree_done           (tree_done),
	.leaf_total          (leaf_total),
	.largest_child_count (largest_child_count),
	.tree_valid          (tree_valid)
);

// ===== bench/tb.sv =====
module tb;
	import pdcc_pkg::*;

	// one expected output beat, field widths as on the ports
	typedef struct packed {
		logic [INDEX_W-1:0] node_index;
		logic [COUNT_W-1:0] child_count;
		logic               run_last;
		logic               tree_done;
		logic [LEAF_W-1:0]  leaf_total;
		logic [COUNT_W-1:0] largest_child_count;
		logic               tree_valid;
	} node_result_t;

	typedef logic [DEPTH_W-1:0] depth_list_t[$];

	localparam int SETTLE_CYCLES = 40;   // block is idle well within this after the last beat
	localparam int PRINT_CAP     = 40;   // stop printing mismatches after this many

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               node_valid = 1'b0;
	logic               node_ready;
	logic [DEPTH_W-1:0] node_depth = '0;
	logic               final_node = 1'b0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic [INDEX_W-1:0] node_index;
	logic [COUNT_W-1:0] child_count;
	logic               run_last;
	logic               tree_done;
	logic [LEAF_W-1:0]  leaf_total;
	logic [COUNT_W-1:0] largest_child_count;
	logic               tree_valid;

	// stimulus / scoreboard bookkeeping
	node_result_t results_due[$];
	int           mismatches = 0;
	int           nodes_sent = 0;
	int           trees_sent = 0;
	int           results_checked = 0;
	int           stalled_offers = 0;
	int           send_gap_max = 5;
	int           recv_gap_max = 5;
	int           hold_cycles = 0;

	// predictor state: mirror of the block's open-ancestor stack and tree totals
	logic [DEPTH_W-1:0] open_depth [STACK_ENTRIES];
	logic [INDEX_W-1:0] open_index [STACK_ENTRIES];
	logic [COUNT_W-1:0] open_kids  [STACK_ENTRIES];
	logic [FILL_W-1:0]  open_fill;
	logic [NEXT_W-1:0]  next_node;
	logic [DEPTH_W-1:0] prev_depth;
	logic [LEAF_W-1:0]  leaves_seen;
	logic [COUNT_W-1:0] most_kids;
	logic               tree_ok;

	preorder_depth_child_counter DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.node_valid          (node_valid),
		.node_ready          (node_ready),
		.node_depth          (node_depth),
		.final_node          (final_node),
		.result_valid        (result_valid),
		.result_ready        (result_ready),
		.node_index          (node_index),
		.child_count         (child_count),
		.run_last            (run_last),
		.tree_done           (tree_done),
		.leaf_total          (leaf_total),
		.largest_child_count (largest_child_count),
		.tree_valid          (tree_valid)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// back to the empty-tree state; stack contents are don't-care at and above open_fill
	task automatic clear_tree;
		open_fill   = '0;
		next_node   = '0;
		prev_depth  = '0;
		leaves_seen = '0;
		most_kids   = '0;
		tree_ok     = 1'b1;
	endtask

	// a node is finished: update totals and build its beat (summary fields filled later)
	function automatic node_result_t close_node(logic [INDEX_W-1:0] idx,
		logic [COUNT_W-1:0] kids);
		node_result_t r;
		r             = '0;
		r.node_index  = idx;
		r.child_count = kids;
		if (kids == 0 && leaves_seen != '1)
			leaves_seen++;
		if (kids > most_kids)
			most_kids = kids;
		if (kids == 1)
			tree_ok = 1'b0;
		return r;
	endfunction

	// work out every beat one accepted node causes and queue them in order
	task automatic count_node(input logic [DEPTH_W-1:0] depth, input logic fin);
		node_result_t       batch[$];
		logic [INDEX_W-1:0] idx;
		// depth may rise by one at most; the first node compares against 0
		if (int'(depth) > int'(prev_depth) + 1)
			tree_ok = 1'b0;
		prev_depth = depth;
		// numbering stops at MAX_NODES; further nodes reuse the wrapped index
		idx = next_node[INDEX_W-1:0];
		if (next_node >= MAX_NODES)
			tree_ok = 1'b0;
		else
			next_node++;
		// close every open ancestor at the same depth or deeper, top first
		while (open_fill > 0 && open_depth[open_fill-1] >= depth) begin
			batch = {batch, close_node(open_index[open_fill-1], open_kids[open_fill-1])};
			open_fill--;
		end
		// new node is a child of whatever is left on top (count saturates)
		if (open_fill > 0 && open_kids[open_fill-1] != '1)
			open_kids[open_fill-1]++;
		if (open_fill < STACK_ENTRIES) begin
			open_depth[open_fill] = depth;
			open_index[open_fill] = idx;
			open_kids[open_fill]  = '0;
			open_fill++;
		end else begin
			// stack full: node goes straight out as a leaf, tree marked bad
			tree_ok = 1'b0;
			batch = {batch, close_node(idx, '0)};
		end
		if (fin) begin
			while (open_fill > 0) begin
				batch = {batch, close_node(open_index[open_fill-1], open_kids[open_fill-1])};
				open_fill--;
			end
		end
		if (batch.size() > 0) begin
			batch[batch.size()-1].run_last = 1'b1;
			if (fin) begin
				batch[batch.size()-1].tree_done           = 1'b1;
				batch[batch.size()-1].leaf_total          = leaves_seen;
				batch[batch.size()-1].largest_child_count = most_kids;
				batch[batch.size()-1].tree_valid          = tree_ok;
			end
		end
		foreach (batch[i])
			results_due = {results_due, batch[i]};
		if (fin)
			clear_tree();
	endtask

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------

	// every mismatch lands here; printing is capped, counting is not
	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP)
			$display("tb: mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("beat %0d %s got %0h want %0h",
				results_checked, name, got, want));
	endtask

	// outputs are sampled at the edge, before the block's updates land
	always @(posedge clk) begin : result_check
		node_result_t want;
		if (arst_n && node_valid && !node_ready)
			stalled_offers++;
		if (arst_n && result_valid && result_ready) begin
			if (results_due.size() == 0) begin
				report_mismatch($sformatf("beat with nothing due, node_index %0h", node_index));
			end else begin
				want = results_due[0];
				results_due.delete(0);
				check_field("node_index", 32'(node_index), 32'(want.node_index));
				check_field("child_count", 32'(child_count), 32'(want.child_count));
				check_field("run_last", 32'(run_last), 32'(want.run_last));
				check_field("tree_done", 32'(tree_done), 32'(want.tree_done));
				check_field("leaf_total", 32'(leaf_total), 32'(want.leaf_total));
				check_field("largest_child_count", 32'(largest_child_count),
					32'(want.largest_child_count));
				check_field("tree_valid", 32'(tree_valid), 32'(want.tree_valid));
			end
			results_checked++;
		end
	end

	// ---------------------------------------------------------------
	// Receiver: random stall before each beat, plus an optional long hold-off
	// ---------------------------------------------------------------
	initial begin : receiver
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				result_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			stall = $urandom_range(0, recv_gap_max);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid)
				@(posedge clk);
		end
	end

	// ---------------------------------------------------------------
	// Sender
	// ---------------------------------------------------------------

	// one node beat; valid stays up across back-to-back beats (gap 0)
	task automatic send_node(input logic [DEPTH_W-1:0] depth, input logic fin);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			node_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		node_valid <= 1'b1;
		node_depth <= depth;
		final_node <= fin;
		@(posedge clk);
		while (!node_ready)
			@(posedge clk);
		count_node(depth, fin);
		nodes_sent++;
	endtask

	// send a run of nodes; when closes is set the last one ends the tree
	task automatic send_tree(input depth_list_t depths, input bit closes);
		for (int i = 0; i < depths.size(); i++)
			send_node(depths[i], closes && (i == depths.size() - 1));
		if (closes)
			trees_sent++;
	endtask

	// drop valid, let every due beat arrive, then give the block time to go idle
	task automatic wait_results_done;
		node_valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// preorder depths: mostly legal steps (one deeper, or back up), some random jumps
	function automatic depth_list_t random_tree(int nodes, int start_depth);
		depth_list_t list;
		int          d;
		d = start_depth;
		for (int i = 0; i < nodes; i++) begin
			if (i > 0) begin
				case ($urandom_range(0, 9))
				0: d = $urandom_range(0, 31);
				1, 2, 3, 4, 5: d = (d < 31) ? d + 1 : d;
				default: d = $urandom_range(0, d);
				endcase
			end
			list = {list, d[DEPTH_W-1:0]};
		end
		return list;
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// lone root, a legal tree, a first node that jumps to depth 31,
	// a single-child root followed by a second root, and a small forest
	task automatic test_small_trees;
		depth_list_t t;
		send_gap_max = 5;
		recv_gap_max = 5;
		t = '{0};
		send_tree(t, 1);
		t = '{0, 1, 1, 2, 2, 1};
		send_tree(t, 1);
		t = '{31};
		send_tree(t, 1);
		t = '{0, 1, 0};
		send_tree(t, 1);
		t = '{0, 1, 2, 2, 1, 1, 0};
		send_tree(t, 1);
		wait_results_done();
	endtask

	// chain down to depth 31 fills the stack; a final sibling at 31 then
	// closes the whole chain in one go (33 beats for one node)
	task automatic test_deep_chain;
		depth_list_t t;
		for (int d = 0; d < 32; d++)
			t = {t, d[DEPTH_W-1:0]};
		t = {t, 5'd31};
		send_tree(t, 1);
		wait_results_done();
	endtask

	// random trees; each tree picks whether both sides pause at random or run flat out
	task automatic test_random_trees;
		depth_list_t t;
		int          sent;
		sent = 0;
		while (sent < 180) begin
			if ($urandom_range(0, 3) == 0) begin
				send_gap_max = 0;
				recv_gap_max = 0;
			end else begin
				send_gap_max = 5;
				recv_gap_max = 5;
			end
			t = random_tree($urandom_range(1, 24),
				($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : 0);
			send_tree(t, 1);
			sent += t.size();
		end
		wait_results_done();
	endtask

	// receiver holds off for a long stretch while nodes keep coming, so the
	// output backs up and the block has to stall its input
	task automatic test_output_hold_off;
		depth_list_t t;
		send_gap_max = 0;
		recv_gap_max = 2;
		hold_cycles  = 300;
		@(posedge clk);
		t = random_tree(50, 0);
		send_tree(t, 1);
		wait_results_done();
	endtask

	// half a tree, sender waits for every due beat, then the tree continues
	task automatic test_mid_tree_pause;
		depth_list_t t;
		send_gap_max = 3;
		recv_gap_max = 3;
		t = '{0, 1, 2, 2, 3, 1, 2};
		send_tree(t, 0);
		wait_results_done();
		t = '{3, 4, 2, 1, 2, 0};
		send_tree(t, 1);
		wait_results_done();
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		clear_tree();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_small_trees();
		test_deep_chain();
		test_random_trees();
		test_output_hold_off();
		test_mid_tree_pause();

		$display("tb: %0d nodes in %0d trees, %0d beats checked, %0d input stall cycles",
			nodes_sent, trees_sent, results_checked, stalled_offers);
		$display("tb: covered depth jumps, single-child nodes, 33-beat flush, hold-off, pause");
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("tb: timeout with %0d beats still due", results_due.size());
		$display("tb: FAIL");
		$finish;
	end

endmodule
